// ===== rtl/asp_pkg.sv =====
package asp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OTHER
  } char_class_t;

  // Commands from the sequencer to the datapath, at most a few per cycle.
  typedef struct packed {
    logic accept;       // input beat taken: latch char, fold in a digit
    logic end_num;      // push the number being built, if any
    logic push_paren;   // push '(' on the operator stack
    logic read_op;      // read top operator
    logic pop_paren;    // drop a leftover '(' at the end, flag underflow
    logic pop_op;       // pop top operator and keep it for the reduction
    logic underflow;    // reduction without two operands
    logic read_b;       // read right operand
    logic read_a;       // keep right operand, read left operand
    logic write_sum;    // replace the two operands by the result
    logic close_paren;  // pop the matching '('
    logic push_op;      // push '+' or '-'
    logic read_top;     // read the final top of the operand stack
    logic emit;         // load the result register, clear the evaluator
  } cmd_t;

  typedef struct packed {
    logic        in_digit;    // payload on the input channel is a digit
    logic        in_last;     // payload on the input channel ends the expression
    logic        last;        // latched character ends the expression
    char_class_t cls;         // class of the latched character
    logic        oper_empty;
    logic        top_paren;   // operator just read is '('
    logic        opnd_lt2;
    logic        out_free;    // result register may be loaded
  } status_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if (c inside {[CH_ZERO:CH_NINE]}) cls = CLS_DIGIT;
    else if (c == CH_SPACE)          cls = CLS_SPACE;
    else if (c == CH_OPEN)           cls = CLS_OPEN;
    else if (c == CH_CLOSE)          cls = CLS_CLOSE;
    else                             cls = CLS_OTHER;
    return cls;
  endfunction

endpackage

// ===== rtl/asp_if.sv =====
interface asp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface asp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink   (input valid, input value, input error_code, output ready);
endinterface

// ===== rtl/asp_ram.sv =====
module asp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/asp_ctrl.sv =====
module asp_ctrl import asp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_END,
    S_FIN_END,
    S_R_CHK,
    S_R_OP,
    S_R_B,
    S_R_A,
    S_POST,
    S_FIN_RD,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   fin, fin_next;   // reducing everything for the final result

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    fin_next   = fin;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.in_digit) state_next = S_END;
          else if (status.in_last) state_next = S_FIN_END;
        end
      end
      S_END: begin
        cmd.end_num = 1'b1;
        case (status.cls)
          CLS_CLOSE, CLS_OTHER: begin
            fin_next   = 1'b0;
            state_next = S_R_CHK;
          end
          default: begin
            cmd.push_paren = (status.cls == CLS_OPEN);
            fin_next       = 1'b1;
            state_next     = status.last ? S_R_CHK : S_IDLE;
          end
        endcase
      end
      S_FIN_END: begin
        cmd.end_num = 1'b1;
        fin_next    = 1'b1;
        state_next  = S_R_CHK;
      end
      S_R_CHK: begin
        if (status.oper_empty) begin
          state_next = fin ? S_FIN_RD : S_POST;
        end else begin
          cmd.read_op = 1'b1;
          state_next  = S_R_OP;
        end
      end
      S_R_OP: begin
        if (status.top_paren) begin
          if (fin) begin
            cmd.pop_paren = 1'b1;
            state_next    = S_R_CHK;
          end else begin
            state_next = S_POST;
          end
        end else begin
          cmd.pop_op = 1'b1;
          if (status.opnd_lt2) begin
            cmd.underflow = 1'b1;
            state_next    = S_R_CHK;
          end else begin
            cmd.read_b = 1'b1;
            state_next = S_R_B;
          end
        end
      end
      S_R_B: begin
        cmd.read_a = 1'b1;
        state_next = S_R_A;
      end
      S_R_A: begin
        cmd.write_sum = 1'b1;
        state_next    = S_R_CHK;
      end
      S_POST: begin
        if (status.cls == CLS_CLOSE) cmd.close_paren = 1'b1;
        else                         cmd.push_op     = 1'b1;
        fin_next   = 1'b1;
        state_next = status.last ? S_R_CHK : S_IDLE;
      end
      S_FIN_RD: begin
        cmd.read_top = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

endmodule

// ===== rtl/asp_dpath.sv =====
module asp_dpath import asp_pkg::*; #(
  parameter int OPERAND_DEPTH  = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  cmd_t       cmd,
  output status_t    status,
  asp_out_if.source  result
);

  localparam int NUM_AW = $clog2(OPERAND_DEPTH);
  localparam int NUM_CW = $clog2(OPERAND_DEPTH + 1);
  localparam int OPR_AW = $clog2(OPERATOR_DEPTH);
  localparam int OPR_CW = $clog2(OPERATOR_DEPTH + 1);

  localparam logic [1:0] OP_PAREN = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SUB   = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  logic [7:0]        char_reg;
  logic              last_reg;
  logic [31:0]       acc;
  logic              active;
  logic [NUM_CW-1:0] opnd_cnt;
  logic [OPR_CW-1:0] oper_cnt;
  logic [1:0]        err;
  logic [1:0]        op_reg;
  logic [31:0]       b_reg;
  logic              top_valid;

  logic [NUM_CW-1:0] opnd_m1, opnd_m2;
  logic [OPR_CW-1:0] oper_m1;
  logic              opnd_full, oper_full;
  logic              push_num, push_any_op;
  logic              ovf, unf;
  logic [31:0]       sum;
  logic [3:0]        digit;

  logic              num_we, num_re;
  logic [NUM_AW-1:0] num_waddr, num_raddr;
  logic [31:0]       num_wdata, num_rdata;
  logic              opr_we;
  logic [1:0]        opr_wdata, opr_rdata;

  assign opnd_m1     = opnd_cnt - NUM_CW'(1);
  assign opnd_m2     = opnd_cnt - NUM_CW'(2);
  assign oper_m1     = oper_cnt - OPR_CW'(1);
  assign opnd_full   = (opnd_cnt >= NUM_CW'(OPERAND_DEPTH));
  assign oper_full   = (oper_cnt >= OPR_CW'(OPERATOR_DEPTH));
  assign push_num    = cmd.end_num && active;
  assign push_any_op = cmd.push_paren || cmd.push_op;
  assign digit       = char_code[3:0];
  assign sum         = (op_reg == OP_ADD) ? (num_rdata + b_reg) : (num_rdata - b_reg);

  // Operand stack: pushes at the count, the reduction result lands two below it.
  assign num_we    = (push_num && !opnd_full) || cmd.write_sum;
  assign num_waddr = cmd.write_sum ? opnd_m2[NUM_AW-1:0] : opnd_cnt[NUM_AW-1:0];
  assign num_wdata = cmd.write_sum ? sum : acc;
  assign num_re    = cmd.read_b || cmd.read_a || cmd.read_top;
  assign num_raddr = cmd.read_a ? opnd_m2[NUM_AW-1:0] : opnd_m1[NUM_AW-1:0];

  assign opr_we    = push_any_op && !oper_full;
  assign opr_wdata = cmd.push_paren ? OP_PAREN : ((char_reg == CH_PLUS) ? OP_ADD : OP_SUB);

  asp_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_num_ram (
    .clk   (clk),
    .we    (num_we),
    .waddr (num_waddr),
    .wdata (num_wdata),
    .re    (num_re),
    .raddr (num_raddr),
    .rdata (num_rdata)
  );

  asp_ram #(.WIDTH(2), .DEPTH(OPERATOR_DEPTH)) u_opr_ram (
    .clk   (clk),
    .we    (opr_we),
    .waddr (oper_cnt[OPR_AW-1:0]),
    .wdata (opr_wdata),
    .re    (cmd.read_op),
    .raddr (oper_m1[OPR_AW-1:0]),
    .rdata (opr_rdata)
  );

  assign ovf = (push_num && opnd_full) || (push_any_op && oper_full);
  assign unf = cmd.underflow || cmd.pop_paren || (cmd.close_paren && oper_cnt == '0);

  always_comb begin
    status.in_digit   = (classify(char_code) == CLS_DIGIT);
    status.in_last    = last_char;
    status.last       = last_reg;
    status.cls        = classify(char_reg);
    status.oper_empty = (oper_cnt == '0);
    status.top_paren  = (opr_rdata == OP_PAREN);
    status.opnd_lt2   = (opnd_cnt < NUM_CW'(2));
    status.out_free   = !result.valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_reg <= char_code;
      last_reg <= last_char;
    end
    if (cmd.pop_op)   op_reg    <= opr_rdata;
    if (cmd.read_a)   b_reg     <= num_rdata;
    if (cmd.read_top) top_valid <= (opnd_cnt != '0);
    if (cmd.emit) begin
      result.value      <= top_valid ? num_rdata : 32'sd0;
      result.error_code <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      active       <= 1'b0;
      opnd_cnt     <= '0;
      oper_cnt     <= '0;
      err          <= ERR_NONE;
      result.valid <= 1'b0;
    end else begin
      if (cmd.accept && status.in_digit) begin
        // acc * 10 + digit, wrapping at 32 bits
        acc    <= active ? ((acc << 3) + (acc << 1) + 32'(digit)) : 32'(digit);
        active <= 1'b1;
      end else if (cmd.end_num) begin
        acc    <= '0;
        active <= 1'b0;
      end

      if (cmd.emit) begin
        opnd_cnt <= '0;
      end else if (push_num && !opnd_full) begin
        opnd_cnt <= opnd_cnt + NUM_CW'(1);
      end else if (cmd.write_sum) begin
        opnd_cnt <= opnd_m1;
      end

      if (cmd.emit) begin
        oper_cnt <= '0;
      end else if (opr_we) begin
        oper_cnt <= oper_cnt + OPR_CW'(1);
      end else if (cmd.pop_op || cmd.pop_paren || (cmd.close_paren && oper_cnt != '0)) begin
        oper_cnt <= oper_m1;
      end

      // first error since the last result sticks
      if (cmd.emit) begin
        err <= ERR_NONE;
      end else if (err == ERR_NONE) begin
        if (ovf)      err <= ERR_OVERFLOW;
        else if (unf) err <= ERR_UNDERFLOW;
      end

      if (cmd.emit)              result.valid <= 1'b1;
      else if (result.ready)     result.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/add_sub_paren_expression_eval.sv =====
// channel  dir  signals                          beat
// expr     in   valid ready char_code last_char  one character
// result   out  valid ready value error_code     one result per last character
// A digit is only accepted; a space or '(' adds the end step, ')', '+' or '-' end, check and post,
// plus an operator read if the reduction stops at '('. Each operator reduced adds operator read,
// two operand reads and write back, each '(' left at the end a check and a pop. The last character
// adds final check, top read and emit, a digit also an end step. Stacks are single RAMs with
// registered reads. Reset is synchronous and does not clear the RAMs or the data registers.
// A result still waiting in the output register holds the evaluator in its emit step, so
// characters after the next last character wait until that result is taken.
module add_sub_paren_expression_eval import asp_pkg::*; #(
  parameter int OPERAND_DEPTH  = 16,
  parameter int OPERATOR_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  asp_in_if.sink    expr,
  asp_out_if.source result
);

  cmd_t    cmd;
  status_t status;
  logic    ready;

  assign expr.ready = ready;

  asp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (expr.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  asp_dpath #(
    .OPERAND_DEPTH  (OPERAND_DEPTH),
    .OPERATOR_DEPTH (OPERATOR_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .char_code (expr.char_code),
    .last_char (expr.last_char),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ===== sim/tb_add_sub_paren_expression_eval.sv =====
module tb_add_sub_paren_expression_eval;
  import asp_pkg::*;

  localparam int STACK_DEPTH  = 16;
  localparam int TOTAL_CHARS  = 1850;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 7;

  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {OPK_PAREN, OPK_ADD, OPK_SUB} opkind_e;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         err;
  } eval_result_t;

  // Evaluator mirror plus the queue of results still owed by the block.
  class expr_scoreboard;
    logic [31:0]  opnd [STACK_DEPTH];
    opkind_e      oper [STACK_DEPTH];
    int unsigned  n_opnd;
    int unsigned  n_oper;
    logic [31:0]  acc;
    bit           acc_on;
    logic [1:0]   err;
    eval_result_t owed_q[$];
    int           fails;
    int           checked;
    int           err_seen[4];
    int unsigned  max_opnd;
    int unsigned  max_oper;

    function new();
      clear();
      fails    = 0;
      checked  = 0;
      max_opnd = 0;
      max_oper = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    function void clear();
      n_opnd = 0;
      n_oper = 0;
      acc    = '0;
      acc_on = 1'b0;
      err    = ERR_NONE;
    endfunction

    function void flag(logic [1:0] code);
      if (err == ERR_NONE) err = code;
    endfunction

    function void push_val(logic [31:0] v);
      if (n_opnd >= STACK_DEPTH) begin
        flag(ERR_OVERFLOW);
      end else begin
        opnd[n_opnd] = v;
        n_opnd++;
        if (n_opnd > max_opnd) max_opnd = n_opnd;
      end
    endfunction

    function void push_op(opkind_e k);
      if (n_oper >= STACK_DEPTH) begin
        flag(ERR_OVERFLOW);
      end else begin
        oper[n_oper] = k;
        n_oper++;
        if (n_oper > max_oper) max_oper = n_oper;
      end
    endfunction

    // operator is popped even when the operands are missing
    function void apply_top();
      opkind_e     k;
      logic [31:0] a;
      logic [31:0] b;
      n_oper--;
      k = oper[n_oper];
      if (n_opnd < 2) begin
        flag(ERR_UNDERFLOW);
        return;
      end
      b = opnd[n_opnd-1];
      a = opnd[n_opnd-2];
      n_opnd -= 2;
      push_val(k == OPK_ADD ? a + b : a - b);
    endfunction

    function void unwind_to_paren();
      while (n_oper > 0 && oper[n_oper-1] != OPK_PAREN) apply_top();
    endfunction

    function void flush_number();
      if (acc_on) begin
        push_val(acc);
        acc_on = 1'b0;
        acc    = '0;
      end
    endfunction

    function void note_char(logic [7:0] c, logic last);
      eval_result_t r;
      logic [31:0]  d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d      = {24'd0, c - CH_ZERO};
        acc    = acc_on ? acc * 32'd10 + d : d;
        acc_on = 1'b1;
      end else begin
        flush_number();
        // a space only ends the number
        if (c == CH_OPEN) begin
          push_op(OPK_PAREN);
        end else if (c == CH_CLOSE) begin
          unwind_to_paren();
          if (n_oper == 0) flag(ERR_UNDERFLOW);
          else n_oper--;
        end else if (c != CH_SPACE) begin
          unwind_to_paren();
          push_op(c == CH_PLUS ? OPK_ADD : OPK_SUB);
        end
      end
      if (!last) return;
      flush_number();
      while (n_oper > 0) begin
        if (oper[n_oper-1] == OPK_PAREN) begin
          n_oper--;
          flag(ERR_UNDERFLOW);
        end else begin
          apply_top();
        end
      end
      r.value = n_opnd > 0 ? opnd[n_opnd-1] : '0;
      r.err   = err;
      owed_q.push_back(r);
      clear();
    endfunction

    function void check_result(logic signed [31:0] value, logic [1:0] code);
      eval_result_t r;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d error_code=%0d", $time, value, code);
        fails++;
        return;
      end
      r = owed_q.pop_front();
      checked++;
      err_seen[r.err]++;
      if (value !== r.value) begin
        $display("%0t: value mismatch: expected %0d actual %0d", $time, r.value, value);
        fails++;
      end
      if (code !== r.err) begin
        $display("%0t: error_code mismatch: expected %0d actual %0d", $time, r.err, code);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  asp_in_if  expr_if ();
  asp_out_if res_if ();

  add_sub_paren_expression_eval u_dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr_if),
    .result (res_if)
  );

  always #4 clk = ~clk;

  expr_scoreboard sb;
  logic [7:0]     text_q[$];
  int             sent_chars = 0;
  int             n_exprs    = 0;
  int             cycles     = 0;
  bit             hold_req   = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed", $time, cycles,
               sb.owed_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- expression text generation ----------------

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_OPEN ||
           c == CH_CLOSE || c == CH_PLUS);
    return c;
  endfunction

  function automatic void maybe_space();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
    end
  endfunction

  // mostly short numbers, now and then long enough to wrap 32 bits
  function automatic void gen_number();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 3);
    repeat (len) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] gen_op();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CH_PLUS;
    if (r < 8) return CH_MINUS;
    return other_char();
  endfunction

  function automatic void gen_term(int depth);
    if (depth < 4 && $urandom_range(0, 3) == 0) begin
      text_q.push_back(CH_OPEN);
      maybe_space();
      gen_expr(depth + 1);
      maybe_space();
      text_q.push_back(CH_CLOSE);
    end else begin
      gen_number();
    end
  endfunction

  function automatic void gen_expr(int depth);
    int n_ops;
    n_ops = $urandom_range(0, 3);
    gen_term(depth);
    repeat (n_ops) begin
      maybe_space();
      text_q.push_back(gen_op());
      maybe_space();
      gen_term(depth);
    end
  endfunction

  // right-nested chain: two operator entries and one operand per level
  function automatic void gen_deep();
    int n;
    n = $urandom_range(6, 20);
    repeat (n) begin
      gen_number();
      text_q.push_back(gen_op());
      text_q.push_back(CH_OPEN);
    end
    gen_number();
    repeat (n) text_q.push_back(CH_CLOSE);
  endfunction

  function automatic void gen_many_operands();
    int n;
    n = $urandom_range(12, 20);
    repeat (n) begin
      gen_number();
      text_q.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 1) == 1) begin
      text_q.push_back(gen_op());
      gen_number();
    end
  endfunction

  function automatic void gen_broken();
    int idx;
    gen_expr(0);
    idx = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: if (text_q.size() > 1) text_q.delete(idx);
      1: text_q.insert(idx, CH_OPEN);
      2: text_q.insert(idx, CH_CLOSE);
      default: text_q.insert(idx, gen_op());
    endcase
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 5))
        0: text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        1: text_q.push_back(CH_SPACE);
        2: text_q.push_back(CH_OPEN);
        3: text_q.push_back(CH_CLOSE);
        4: text_q.push_back(CH_PLUS);
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // ---------------- drivers ----------------

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_text(input int gap_max);
    int gap;
    bit is_last;
    for (int i = 0; i < text_q.size(); i++) begin
      gap     = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      is_last = (i == text_q.size() - 1);
      if (gap > 0) begin
        expr_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      expr_if.valid     <= 1'b1;
      expr_if.char_code <= text_q[i];
      expr_if.last_char <= is_last;
      do @(posedge clk); while (!expr_if.ready);
      sb.note_char(text_q[i], is_last);
      sent_chars++;
      @(negedge clk);
    end
    text_q.delete();
    n_exprs++;
  endtask

  task automatic wait_all_results();
    expr_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side
  initial begin
    int gap_max;
    int gap;
    res_if.ready = 1'b0;
    gap_max = MAX_GAP;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) gap_max = (gap_max == 0) ? MAX_GAP : 0;
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      sb.check_result(res_if.value, res_if.error_code);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    int r;
    int gap_max;
    sb = new();
    expr_if.valid     = 1'b0;
    expr_if.char_code = '0;
    expr_if.last_char = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: parentheses, unmatched ones, lone operator, empty, odd minus codes
    put_str("(1+2)");
    send_text(0);
    put_str(")");
    send_text(0);
    put_str("(");
    send_text(MAX_GAP);
    put_str("+");
    send_text(0);
    put_str(" ");
    send_text(0);
    put_str("9");
    text_q.push_back(8'h00);
    put_str("4");
    send_text(MAX_GAP);
    text_q.push_back(8'hFF);
    put_str("2");
    send_text(0);
    put_str("0-2147483648");
    send_text(0);
    wait_all_results();

    while (sent_chars < TOTAL_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 60) gen_expr(0);
      else if (r < 70) gen_deep();
      else if (r < 78) gen_many_operands();
      else if (r < 88) gen_broken();
      else gen_noise();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      if (n_exprs == 30 || n_exprs == 120) begin
        hold_req = 1'b1;
        gap_max  = 0;
      end
      send_text(gap_max);
      if (n_exprs == 60 || $urandom_range(0, 19) == 0) wait_all_results();
    end

    expr_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.owed_q.size());
      sb.fails++;
    end
    $display("Sent %0d characters in %0d expressions, checked %0d results", sent_chars,
             n_exprs, sb.checked);
    $display("Error results: overflow %0d, underflow %0d; peak depth operands %0d operators %0d",
             sb.err_seen[ERR_OVERFLOW], sb.err_seen[ERR_UNDERFLOW], sb.max_opnd, sb.max_oper);
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
